FILE: hdl/ble_adp_pkg.sv
// Shared types and constants for the advertising-data structure parser.
// Used by ble_adp_core, ble_adv_data_parser and ble_adp_checker; no dependencies.
`default_nettype none

package ble_adp_pkg;

    // Parser phase codes. Code 3 is never entered and behaves as PH_LENGTH.
    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_TYPE   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    // Decoded service kinds.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TEMP  = 2'd1;
    localparam logic [1:0] KIND_BATT  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [7:0]  AD_SERVICE_DATA_16 = 8'h16;
    localparam logic [15:0] UUID_TEMPERATURE   = 16'h1809;
    localparam logic [15:0] UUID_BATTERY       = 16'h180f;
    localparam logic [7:0]  BUDGET_RESET       = 8'd31;

    // Data byte positions within a service-data structure.
    localparam logic [7:0] IDX_UUID_LO = 8'd0;
    localparam logic [7:0] IDX_UUID_HI = 8'd1;
    localparam logic [7:0] IDX_VAL_0   = 8'd2;
    localparam logic [7:0] IDX_VAL_1   = 8'd3;
    localparam logic [7:0] IDX_VAL_2   = 8'd4;
    localparam logic [7:0] IDX_MAX     = 8'hff;

    // One finished-structure result.
    typedef struct packed {
        logic [7:0]  struct_type;
        logic [7:0]  struct_length;
        logic [15:0] service_uuid;
        logic [1:0]  decoded_kind;
        logic [23:0] temperature_raw;
        logic [7:0]  battery_percent;
        logic        truncated;
        logic        payload_done;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/ble_adp_core.sv
// Parser state and the single-pass step logic for one payload byte.
// Depends on ble_adp_pkg.
`default_nettype none

module ble_adp_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step_en,
    input  wire logic [7:0]           adv_byte,
    input  wire logic                 first_of_payload,
    input  wire logic [7:0]           budget,
    output logic                      res_valid,
    output ble_adp_pkg::result_t      res
);

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  cons_reg, cons_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] uuid_reg, uuid_next;
    logic [23:0] val_reg, val_next;
    logic        over_reg, over_next;
    logic        trunc, done;

    always_comb begin
        logic at_budget;
        at_budget  = 1'b0;
        phase_next = phase_reg;
        left_next  = left_reg;
        cons_next  = cons_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        idx_next   = idx_reg;
        uuid_next  = uuid_reg;
        val_next   = val_reg;
        over_next  = over_reg;
        res_valid  = 1'b0;
        trunc      = 1'b0;
        done       = 1'b0;

        if (step_en) begin
            if (first_of_payload) begin
                phase_next = ble_adp_pkg::PH_LENGTH;
                cons_next  = '0;
                len_next   = '0;
                type_next  = '0;
                idx_next   = '0;
                left_next  = '0;
                uuid_next  = '0;
                val_next   = '0;
                over_next  = 1'b0;
            end
            if (!over_next) begin
                cons_next = cons_next + 8'd1;
                at_budget = (cons_next >= budget);
                unique case (phase_next)
                    ble_adp_pkg::PH_TYPE: begin
                        type_next = adv_byte;
                        left_next = left_next - 8'd1;
                        if (left_next == 8'd0) begin
                            phase_next = ble_adp_pkg::PH_LENGTH;
                            res_valid  = 1'b1;
                            done       = at_budget;
                        end else begin
                            phase_next = ble_adp_pkg::PH_DATA;
                            res_valid  = at_budget;
                            trunc      = 1'b1;
                            done       = 1'b1;
                        end
                    end
                    ble_adp_pkg::PH_DATA: begin
                        if (type_next == ble_adp_pkg::AD_SERVICE_DATA_16) begin
                            case (idx_next)
                                ble_adp_pkg::IDX_UUID_LO: uuid_next[7:0]   |= adv_byte;
                                ble_adp_pkg::IDX_UUID_HI: uuid_next[15:8]  |= adv_byte;
                                ble_adp_pkg::IDX_VAL_0:   val_next[7:0]    |= adv_byte;
                                ble_adp_pkg::IDX_VAL_1:   val_next[15:8]   |= adv_byte;
                                ble_adp_pkg::IDX_VAL_2:   val_next[23:16]  |= adv_byte;
                                default: ;
                            endcase
                        end
                        if (idx_next != ble_adp_pkg::IDX_MAX) begin
                            idx_next = idx_next + 8'd1;
                        end
                        left_next = left_next - 8'd1;
                        if (left_next == 8'd0) begin
                            phase_next = ble_adp_pkg::PH_LENGTH;
                            res_valid  = 1'b1;
                            done       = at_budget;
                        end else begin
                            res_valid  = at_budget;
                            trunc      = 1'b1;
                            done       = 1'b1;
                        end
                    end
                    default: begin
                        // Length byte; the unused phase code lands here as well.
                        len_next  = '0;
                        type_next = '0;
                        idx_next  = '0;
                        left_next = '0;
                        uuid_next = '0;
                        val_next  = '0;
                        if (adv_byte == 8'd0) begin
                            phase_next = ble_adp_pkg::PH_LENGTH;
                            res_valid  = 1'b1;
                            done       = 1'b1;
                        end else begin
                            len_next   = adv_byte;
                            left_next  = adv_byte;
                            phase_next = ble_adp_pkg::PH_TYPE;
                            res_valid  = at_budget;
                            trunc      = 1'b1;
                            done       = 1'b1;
                        end
                    end
                endcase
                if (res_valid && done) begin
                    over_next = 1'b1;
                end
            end
        end
    end

    // Service decode from the structure as it stands after this byte.
    always_comb begin
        res                 = '0;
        res.struct_type     = type_next;
        res.struct_length   = len_next;
        res.truncated       = trunc;
        res.payload_done    = done;
        if (type_next == ble_adp_pkg::AD_SERVICE_DATA_16 && idx_next >= 8'd2) begin
            res.service_uuid = uuid_next;
            if (uuid_next == ble_adp_pkg::UUID_TEMPERATURE && idx_next >= 8'd5) begin
                res.decoded_kind    = ble_adp_pkg::KIND_TEMP;
                res.temperature_raw = val_next;
            end else if (uuid_next == ble_adp_pkg::UUID_BATTERY && idx_next >= 8'd3) begin
                res.decoded_kind    = ble_adp_pkg::KIND_BATT;
                res.battery_percent = val_next[7:0];
            end else begin
                res.decoded_kind    = ble_adp_pkg::KIND_OTHER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ble_adp_pkg::PH_LENGTH;
            left_reg  <= '0;
            cons_reg  <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            idx_reg   <= '0;
            uuid_reg  <= '0;
            val_reg   <= '0;
            over_reg  <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            cons_reg  <= cons_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            idx_reg   <= idx_next;
            uuid_reg  <= uuid_next;
            val_reg   <= val_next;
            over_reg  <= over_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ble_adv_data_parser.sv
// Path: an accepted byte request is held in the input register, and its parser step result
// is registered in the result register, which drives m_tvalid.
// Throughput: one byte request per cycle while the sink takes results; a result held
// by the sink stalls the parser, and intake stops once the input register is full as well.
// Reset (aresetn low, synchronous) empties both registers, returns the parser to
// waiting for a first-of-payload byte and sets the byte budget to 31.
//
// Depends on ble_adp_pkg and ble_adp_core.
`default_nettype none

module ble_adv_data_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: payload byte budget.
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // Byte stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] adv_byte
    input  wire logic        s_tuser,   // [0] first_of_payload
    // Structure results out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] struct_type, [15:8] struct_length, [31:16] service_uuid,
    // [33:32] decoded_kind, [57:34] temperature_raw, [65:58] battery_percent,
    // [71:66] zero
    output logic [71:0]      m_tdata,
    output logic             m_tuser,   // [0] truncated
    output logic             m_tlast    // payload_done
);

    logic                  in_vld_reg, in_vld_next;
    logic [7:0]            in_byte_reg;
    logic                  in_first_reg;
    logic [7:0]            budget_reg;
    logic                  out_vld_reg, out_vld_next;
    ble_adp_pkg::result_t  out_res_reg;
    logic                  advance;
    logic                  res_valid;
    ble_adp_pkg::result_t  res;

    // The held byte moves into the parser whenever the result register is free
    // or is being emptied in this same cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (advance) begin
            in_vld_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = res_valid;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    ble_adp_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (advance),
        .adv_byte         (in_byte_reg),
        .first_of_payload (in_first_reg),
        .budget           (budget_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            budget_reg  <= ble_adp_pkg::BUDGET_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0,
                       out_res_reg.battery_percent,
                       out_res_reg.temperature_raw,
                       out_res_reg.decoded_kind,
                       out_res_reg.service_uuid,
                       out_res_reg.struct_length,
                       out_res_reg.struct_type};
    assign m_tuser  = out_res_reg.truncated;
    assign m_tlast  = out_res_reg.payload_done;

endmodule

`default_nettype wire

FILE: hdl/ble_adp_checker.sv
// Port-level checks for ble_adv_data_parser, attached by the bind below.
// Depends on ble_adp_pkg.
`default_nettype none

module ble_adp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A result stalled by the sink keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // A structure cut off by the budget is always the last one of its payload.
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("truncated result without payload end");

    // Without a decoded service, every decoded field reads zero.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] == ble_adp_pkg::KIND_NONE |->
            m_tdata[31:16] == 16'd0 && m_tdata[57:34] == 24'd0 && m_tdata[65:58] == 8'd0)
        else $error("undecoded result carries service fields");

    // A temperature result always comes from service data with the temperature UUID.
    a_temp_uuid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] == ble_adp_pkg::KIND_TEMP |->
            m_tdata[31:16] == ble_adp_pkg::UUID_TEMPERATURE
            && m_tdata[7:0] == ble_adp_pkg::AD_SERVICE_DATA_16
            && m_tdata[65:58] == 8'd0)
        else $error("temperature result with wrong service");

    // The terminator has no type and no length.
    a_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15:8] == 8'd0 |-> m_tdata[7:0] == 8'd0 && m_tlast && !m_tuser)
        else $error("malformed terminator result");

endmodule

bind ble_adv_data_parser ble_adp_checker u_ble_adp_checker (.*);

`default_nettype wire
